// ----- rtl/core/tpq_pkg.sv -----
// Shared constants and codes for the threshold priority queue.
// No dependencies; imported by the queue top level and its checker.
`default_nettype none

package tpq_pkg;

   // Default sizing, handed to the top level's parameters
   localparam int QUEUE_DEPTH_DEFAULT   = 32;
   localparam int PRIORITY_BITS_DEFAULT = 4;
   localparam int ID_BITS_DEFAULT       = 16;

   // Register file
   localparam int TAIL_LIMIT_RESET = 4;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_INDEX_BIT    = 2;
   localparam logic CSR_IDX_TAIL_LIMIT = 1'b0;

   // Command codes
   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_SEARCH  = 2'd2;

   // Result status
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/tpq_store.sv -----
// Slot storage for the threshold priority queue: one write port, one
// registered read port. No package dependencies.
`default_nettype none

module tpq_store #(
   parameter int DEPTH     = 32,
   parameter int DATA_BITS = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0]     wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/threshold_priority_queue_unit.sv -----
// Threshold priority queue top level: sequencer, head and count registers,
// register port and result register. Uses tpq_pkg and tpq_store.
`default_nettype none

// Usage
//  - req channel (req_valid/req_ready) carries one command beat: enqueue an
//    id with a priority, dequeue the head, or search for an id.
//  - rsp channel (rsp_valid/rsp_ready) returns one beat per command: status,
//    insert position, removed entry, search hit, head id and entry count.
//  - APB-style port sets tail_priority_limit (index 0, byte address 0);
//    pready is tied high. Write it only while the queue is quiet.
//  - One command at a time: req_ready is high only while the sequencer is
//    idle and rises with rsp_valid. An enqueue to the tail writes its slot
//    directly; one above the limit scans for its place, shifts any slots
//    behind it up and then writes; a dequeue shifts every slot down; a
//    search scans until a hit or the tail; full, empty and unused commands
//    go straight to the result. Scans and shifts are paced by the single
//    read port of the slot store: the shared compare unit sees one slot per
//    cycle, and every shift moves one slot per cycle.
//  - Reset empties the queue and loads the tail limit with its reset value;
//    slot contents are left as they are and are never read before written.
//  - A stalled receiver holds the result beat in the output register; the
//    next command is still accepted and runs, then waits for the register.
module threshold_priority_queue_unit
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
   parameter int ID_BITS       = ID_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_cmd,
   input  wire logic [ID_BITS-1:0]                 req_patient_id,
   input  wire logic [PRIORITY_BITS-1:0]           req_priority_req,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [$clog2(QUEUE_DEPTH)-1:0]          rsp_position,
   output logic [ID_BITS-1:0]                      rsp_removed_id,
   output logic [PRIORITY_BITS-1:0]                rsp_removed_priority,
   output logic                                    rsp_found,
   output logic [ID_BITS-1:0]                      rsp_head_id,
   output logic                                    rsp_head_valid,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        rsp_entry_total,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]           paddr,
   input  wire logic [CSR_DATA_BITS-1:0]           pwdata,
   output logic [CSR_DATA_BITS-1:0]                prdata,
   output logic                                    pready
);

   localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_BITS = ID_BITS + PRIORITY_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE    = CNT_BITS'(1);
   localparam logic [ADDR_BITS-1:0] ADDR_ONE  = ADDR_BITS'(1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SHIFT_UP = 6'b000100,
      ST_PLACE    = 6'b001000,
      ST_SHIFT_DN = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   // Sequencer and command registers
   state_type                 state_ff, state_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic [ID_BITS-1:0]        id_ff, id_in;
   logic [PRIORITY_BITS-1:0]  prio_ff, prio_in;
   logic [CNT_BITS-1:0]       idx_ff, idx_in;
   logic [ADDR_BITS-1:0]      pos_ff, pos_in;
   logic                      rvalid_ff, rvalid_in;
   logic [ADDR_BITS-1:0]      raddr_ff, raddr_in;

   // Queue state kept beside the store
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [ID_BITS-1:0]        head_id_ff, head_id_in;
   logic [PRIORITY_BITS-1:0]  head_prio_ff, head_prio_in;
   logic [PRIORITY_BITS-1:0]  limit_ff, limit_in;

   // Result being assembled
   status_type                res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0]      res_pos_ff, res_pos_in;
   logic                      res_found_ff, res_found_in;
   logic [ID_BITS-1:0]        res_rid_ff, res_rid_in;
   logic [PRIORITY_BITS-1:0]  res_rprio_ff, res_rprio_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [ID_BITS-1:0]        rsp_rid_ff, rsp_rid_in;
   logic [PRIORITY_BITS-1:0]  rsp_rprio_ff, rsp_rprio_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [ID_BITS-1:0]        rsp_head_ff, rsp_head_in;
   logic                      rsp_hvalid_ff, rsp_hvalid_in;
   logic [CNT_BITS-1:0]       rsp_total_ff, rsp_total_in;

   // Store ports
   logic                      wr_en;
   logic [ADDR_BITS-1:0]      wr_addr;
   logic [DATA_BITS-1:0]      wr_data;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic [DATA_BITS-1:0]      rd_data;
   logic [ID_BITS-1:0]        rd_id;
   logic [PRIORITY_BITS-1:0]  rd_prio;

   logic                      cmp_hit;
   logic                      csr_wr;

   tpq_store #(
      .DEPTH     (QUEUE_DEPTH),
      .DATA_BITS (DATA_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id   = rd_data[DATA_BITS-1:PRIORITY_BITS];
   assign rd_prio = rd_data[PRIORITY_BITS-1:0];

   // Shared compare unit: id match for search, strictly-lower priority for
   // insertion. Only meaningful when a read came back this cycle.
   always_comb begin
      if (cmd_ff == CMD_SEARCH) begin
         cmp_hit = rvalid_ff && (rd_id == id_ff);
      end else begin
         cmp_hit = rvalid_ff && (rd_prio < prio_ff);
      end
   end

   // Register port: index taken from the word address bit
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_INDEX_BIT] == CSR_IDX_TAIL_LIMIT);

   always_comb begin
      if (paddr[CSR_INDEX_BIT] == CSR_IDX_TAIL_LIMIT) begin
         prdata = CSR_DATA_BITS'(limit_ff);
      end else begin
         prdata = '0;
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr) begin
         limit_in = pwdata[PRIORITY_BITS-1:0];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      rvalid_in     = 1'b0;
      raddr_in      = raddr_ff;
      count_in      = count_ff;
      head_id_in    = head_id_ff;
      head_prio_in  = head_prio_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_found_in  = res_found_ff;
      res_rid_in    = res_rid_ff;
      res_rprio_in  = res_rprio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rid_in    = rsp_rid_ff;
      rsp_rprio_in  = rsp_rprio_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_hvalid_in = rsp_hvalid_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               id_in         = req_patient_id;
               prio_in       = req_priority_req;
               res_status_in = STATUS_OK;
               res_pos_in    = '0;
               res_found_in  = 1'b0;
               res_rid_in    = '0;
               res_rprio_in  = '0;
               unique case (req_cmd)
                  CMD_ENQUEUE: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_RESP;
                     end else if ((req_priority_req <= limit_ff) || (count_ff == '0)) begin
                        // tail append: no scan, no shift
                        pos_in   = count_ff[ADDR_BITS-1:0];
                        state_in = ST_PLACE;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        state_in      = ST_RESP;
                     end else begin
                        res_rid_in   = head_id_ff;
                        res_rprio_in = head_prio_ff;
                        idx_in       = CNT_ONE;
                        state_in     = ST_SHIFT_DN;
                     end
                  end
                  CMD_SEARCH: begin
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // one slot per cycle through the compare unit
            if (cmp_hit) begin
               if (cmd_ff == CMD_SEARCH) begin
                  res_found_in = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  pos_in   = raddr_ff;
                  idx_in   = count_ff;
                  state_in = ST_SHIFT_UP;
               end
            end else if (idx_ff == count_ff) begin
               if (cmd_ff == CMD_SEARCH) begin
                  state_in = ST_RESP;
               end else begin
                  pos_in   = count_ff[ADDR_BITS-1:0];
                  state_in = ST_PLACE;
               end
            end else begin
               rd_addr   = idx_ff[ADDR_BITS-1:0];
               rvalid_in = 1'b1;
               raddr_in  = idx_ff[ADDR_BITS-1:0];
               idx_in    = idx_ff + CNT_ONE;
            end
         end

         ST_SHIFT_UP: begin
            // open a gap at pos: move each slot up by one, tail first
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = raddr_ff + ADDR_ONE;
               wr_data = rd_data;
            end
            if (idx_ff > CNT_BITS'(pos_ff)) begin
               rd_addr   = ADDR_BITS'(idx_ff - CNT_ONE);
               rvalid_in = 1'b1;
               raddr_in  = ADDR_BITS'(idx_ff - CNT_ONE);
               idx_in    = idx_ff - CNT_ONE;
            end else begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {id_ff, prio_ff};
            if (pos_ff == '0) begin
               head_id_in   = id_ff;
               head_prio_in = prio_ff;
            end
            res_pos_in = pos_ff;
            count_in   = count_ff + CNT_ONE;
            state_in   = ST_RESP;
         end

         ST_SHIFT_DN: begin
            // close the head: move each slot down by one
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = raddr_ff - ADDR_ONE;
               wr_data = rd_data;
               if (raddr_ff == ADDR_ONE) begin
                  head_id_in   = rd_id;
                  head_prio_in = rd_prio;
               end
            end
            if (idx_ff < count_ff) begin
               rd_addr   = idx_ff[ADDR_BITS-1:0];
               rvalid_in = 1'b1;
               raddr_in  = idx_ff[ADDR_BITS-1:0];
               idx_in    = idx_ff + CNT_ONE;
            end else begin
               count_in = count_ff - CNT_ONE;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_rid_in    = res_rid_ff;
               rsp_rprio_in  = res_rprio_ff;
               rsp_found_in  = res_found_ff;
               rsp_hvalid_in = (count_ff != '0);
               rsp_head_in   = (count_ff != '0) ? head_id_ff : '0;
               rsp_total_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rvalid_ff    <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= PRIORITY_BITS'(TAIL_LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= rvalid_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      raddr_ff      <= raddr_in;
      head_id_ff    <= head_id_in;
      head_prio_ff  <= head_prio_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_found_ff  <= res_found_in;
      res_rid_ff    <= res_rid_in;
      res_rprio_ff  <= res_rprio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_rid_ff    <= rsp_rid_in;
      rsp_rprio_ff  <= rsp_rprio_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_position         = rsp_pos_ff;
   assign rsp_removed_id       = rsp_rid_ff;
   assign rsp_removed_priority = rsp_rprio_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_head_id          = rsp_head_ff;
   assign rsp_head_valid       = rsp_hvalid_ff;
   assign rsp_entry_total      = rsp_total_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tpq_checker.sv -----
// Port-level checks for the threshold priority queue, bound to its top
// level. Uses tpq_pkg.
`default_nettype none

module tpq_checker
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = ID_BITS_DEFAULT
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [1:0]                         rsp_status,
   input wire logic [ID_BITS-1:0]                 rsp_head_id,
   input wire logic                               rsp_head_valid,
   input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_entry_total
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

   // count never exceeds the depth
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_total <= FULL_COUNT))
      else $error("entry total beyond queue depth");

   // head flag tracks the count
   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_entry_total != '0)))
      else $error("head flag disagrees with entry total");

   // drop only when full
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (rsp_entry_total == FULL_COUNT))
      else $error("full status with room left");

   // empty dequeue leaves an empty queue with a zero head
   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |->
         (!rsp_head_valid && (rsp_head_id == '0)))
      else $error("empty status with entries held");

   // stalled result beat stays valid with a stable entry total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_entry_total)))
      else $error("result beat changed under stall");

endmodule

bind threshold_priority_queue_unit tpq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .ID_BITS     (ID_BITS)
) u_tpq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_head_id     (rsp_head_id),
   .rsp_head_valid  (rsp_head_valid),
   .rsp_entry_total (rsp_entry_total)
);

`default_nettype wire

// ----- tb/threshold_priority_queue_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the threshold priority queue: watches the command, result and
// register ports, predicts each result beat and compares it. Uses tpq_pkg.
module threshold_priority_queue_checker
   import tpq_pkg::*;
(
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic [1:0]                                   req_cmd,
   input  logic [ID_BITS_DEFAULT-1:0]                   req_patient_id,
   input  logic [PRIORITY_BITS_DEFAULT-1:0]             req_priority_req,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic [1:0]                                   rsp_status,
   input  logic [$clog2(QUEUE_DEPTH_DEFAULT)-1:0]       rsp_position,
   input  logic [ID_BITS_DEFAULT-1:0]                   rsp_removed_id,
   input  logic [PRIORITY_BITS_DEFAULT-1:0]             rsp_removed_priority,
   input  logic                                         rsp_found,
   input  logic [ID_BITS_DEFAULT-1:0]                   rsp_head_id,
   input  logic                                         rsp_head_valid,
   input  logic [$clog2(QUEUE_DEPTH_DEFAULT+1)-1:0]     rsp_entry_total,
   input  logic                                         psel,
   input  logic                                         penable,
   input  logic                                         pwrite,
   input  logic                                         pready,
   input  logic [CSR_ADDR_BITS-1:0]                     paddr,
   input  logic [CSR_DATA_BITS-1:0]                     pwdata,
   output int                                           pending,
   output int                                           fail_count
);

   localparam int DEPTH   = QUEUE_DEPTH_DEFAULT;
   localparam int PRIO_W  = PRIORITY_BITS_DEFAULT;
   localparam int ID_W    = ID_BITS_DEFAULT;
   localparam int POS_W   = $clog2(DEPTH);
   localparam int TOTAL_W = $clog2(DEPTH + 1);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [ID_W-1:0]    removed_id;
      logic [PRIO_W-1:0]  removed_prio;
      logic               found;
      logic [ID_W-1:0]    head_id;
      logic               head_valid;
      logic [TOTAL_W-1:0] entry_total;
   } queue_result_type;

   // shadow of the queue contents and the tail limit register
   logic [ID_W-1:0]   held_ids   [DEPTH];
   logic [PRIO_W-1:0] held_prios [DEPTH];
   int                held_count;
   logic [PRIO_W-1:0] tail_limit;

   queue_result_type  expected_results [$];
   int                failures = 0;

   // Work out the result of one command and advance the shadow queue.
   function automatic queue_result_type apply_command(input logic [1:0] cmd,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [PRIO_W-1:0] prio);
      queue_result_type r;
      int               slot;
      bit               placed;
      r        = '0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot   = held_count;
               placed = 1'b0;
               // above the limit: go ahead of the first strictly lower priority
               if (prio > tail_limit && held_count != 0) begin
                  for (int i = 0; i < held_count; i++) begin
                     if (!placed && held_prios[i] < prio) begin
                        slot   = i;
                        placed = 1'b1;
                     end
                  end
               end
               for (int i = held_count; i > slot; i--) begin
                  held_ids[i]   = held_ids[i-1];
                  held_prios[i] = held_prios[i-1];
               end
               held_ids[slot]   = id;
               held_prios[slot] = prio;
               held_count++;
               r.position = POS_W'(slot);
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.removed_id   = held_ids[0];
               r.removed_prio = held_prios[0];
               for (int i = 1; i < held_count; i++) begin
                  held_ids[i-1]   = held_ids[i];
                  held_prios[i-1] = held_prios[i];
               end
               held_count--;
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < held_count; i++)
               if (held_ids[i] == id) r.found = 1'b1;
         end
         default: ;
      endcase
      r.head_valid  = (held_count != 0);
      r.head_id     = (held_count != 0) ? held_ids[0] : '0;
      r.entry_total = TOTAL_W'(held_count);
      return r;
   endfunction

   function automatic string describe(input queue_result_type r);
      return $sformatf("status=%0d pos=%0d removed=%04h/%0d found=%0b head=%04h/%0b total=%0d",
                       r.status, r.position, r.removed_id, r.removed_prio, r.found,
                       r.head_id, r.head_valid, r.entry_total);
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin : track
      queue_result_type got;
      queue_result_type want;
      bit               bad;
      if (reset) begin
         held_count = 0;
         tail_limit = PRIO_W'(TAIL_LIMIT_RESET);
         expected_results.delete();
      end else begin
         // check the result beat first: it always belongs to an older command
         if (rsp_valid && rsp_ready) begin
            got.status       = status_type'(rsp_status);
            got.position     = rsp_position;
            got.removed_id   = rsp_removed_id;
            got.removed_prio = rsp_removed_priority;
            got.found        = rsp_found;
            got.head_id      = rsp_head_id;
            got.head_valid   = rsp_head_valid;
            got.entry_total  = rsp_entry_total;
            if (expected_results.size() == 0) begin
               note_failure({"unexpected result beat: ", describe(got)});
            end else begin
               want = expected_results.pop_front();
               bad  = (got.status       !== want.status)       ||
                      (got.position     !== want.position)     ||
                      (got.removed_id   !== want.removed_id)   ||
                      (got.removed_prio !== want.removed_prio) ||
                      (got.found        !== want.found)        ||
                      (got.head_id      !== want.head_id)      ||
                      (got.head_valid   !== want.head_valid)   ||
                      (got.entry_total  !== want.entry_total);
               if (bad)
                  note_failure({"result mismatch: expected ", describe(want),
                                " got ", describe(got)});
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_command(req_cmd, req_patient_id,
                                                     req_priority_req));
         if (psel && penable && pwrite && pready &&
             (paddr >> CSR_INDEX_BIT) == CSR_ADDR_BITS'(CSR_IDX_TAIL_LIMIT))
            tail_limit = pwdata[PRIO_W-1:0];
      end
      pending    <= expected_results.size();
      fail_count <= failures;
   end

endmodule

// ----- tb/tb_threshold_priority_queue_unit.sv -----
`timescale 1ns / 100ps
// Top of the threshold priority queue testbench: clock, reset, command and register
// stimulus, result back-pressure and verdict. Uses tpq_pkg and the result checker.
module tb_threshold_priority_queue_unit;
   import tpq_pkg::*;

   localparam int PRIO_W  = PRIORITY_BITS_DEFAULT;
   localparam int ID_W    = ID_BITS_DEFAULT;
   localparam int POS_W   = $clog2(QUEUE_DEPTH_DEFAULT);
   localparam int TOTAL_W = $clog2(QUEUE_DEPTH_DEFAULT + 1);

   // command code the block leaves unused; it must behave as a no-op
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [CSR_ADDR_BITS-1:0] TAIL_LIMIT_ADDR =
      CSR_ADDR_BITS'(CSR_IDX_TAIL_LIMIT) << CSR_INDEX_BIT;

   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_BEATS   = 140;
   // covers the slowest insert, into a queue holding 31 entries, with margin on top
   localparam int SETTLE_CYCLES = 72;
   // sits far above the longest quiet stretch of a correct run
   localparam int WATCHDOG_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_cmd;
   logic [ID_W-1:0]        req_patient_id;
   logic [PRIO_W-1:0]      req_priority_req;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_status;
   logic [POS_W-1:0]       rsp_position;
   logic [ID_W-1:0]        rsp_removed_id;
   logic [PRIO_W-1:0]      rsp_removed_priority;
   logic                   rsp_found;
   logic [ID_W-1:0]        rsp_head_id;
   logic                   rsp_head_valid;
   logic [TOTAL_W-1:0]     rsp_entry_total;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                   pready;

   int pending;
   int fail_count;
   int burst_left   = 0;   // beats left before the sender takes a gap
   bit beat_held    = 0;   // req_valid was left high after the last beat
   int stall_run    = 0;   // cycles the receiver keeps its current ready level
   int quiet_cycles = 0;

   threshold_priority_queue_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_patient_id       (req_patient_id),
      .req_priority_req     (req_priority_req),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_position         (rsp_position),
      .rsp_removed_id       (rsp_removed_id),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_found            (rsp_found),
      .rsp_head_id          (rsp_head_id),
      .rsp_head_valid       (rsp_head_valid),
      .rsp_entry_total      (rsp_entry_total),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   threshold_priority_queue_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_patient_id       (req_patient_id),
      .req_priority_req     (req_priority_req),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_position         (rsp_position),
      .rsp_removed_id       (rsp_removed_id),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_found            (rsp_found),
      .rsp_head_id          (rsp_head_id),
      .rsp_head_valid       (rsp_head_valid),
      .rsp_entry_total      (rsp_entry_total),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .pready               (pready),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .pending              (pending),
      .fail_count           (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: alternate hard stalls, free-running stretches and a per-cycle coin
   // toss, so that back-pressure lands on every stage of a command.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b0;
               stall_run <= $urandom_range(1, 10);
            end
            1: begin
               rsp_ready <= 1'b1;
               stall_run <= $urandom_range(10, 60);
            end
            default: rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // Watchdog: any beat on either channel or a register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_threshold_priority_queue_unit NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one command beat and hold it until accepted. Bursts end in a random
   // gap; long bursts give stretches with no idling at all.
   task automatic issue(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                        input logic [PRIO_W-1:0] prio);
      int gap;
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_patient_id   <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
         beat_held = 1'b1;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
         gap        = $urandom_range(1, 12);
         req_valid <= 1'b0;
         beat_held  = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every result beat has come back.
   task automatic drain;
      if (beat_held) req_valid <= 1'b0;
      beat_held = 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup then access phase; the register takes the value on the access edge.
   task automatic write_tail_limit(input logic [PRIO_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TAIL_LIMIT_ADDR;
      pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Ids mostly from a small pool so that searches hit, with the extremes and
   // full-range values mixed in.
   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 3))
         0, 1: return ID_W'($urandom_range(0, 31));
         2:    return ID_W'($urandom_range(0, 65535));
         default: return ID_W'(16'hFFFF - $urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      int            phase;
      int            n;
      int            enq_share;
      int            roll;
      logic [1:0]    cmd;
      logic [PRIO_W-1:0] limit;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_ENQUEUE;
      req_patient_id   <= '0;
      req_priority_req <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, tail limit at its reset value of 4.
      issue(CMD_DEQUEUE, 16'h0000, 4'h0);   // dequeue on an empty queue
      issue(CMD_SEARCH,  16'h0000, 4'h0);   // search on an empty queue
      issue(CMD_UNUSED,  16'h0000, 4'h0);   // unused command, queue empty
      issue(CMD_ENQUEUE, 16'h0000, 4'hF);   // above the limit, but empty: tail
      issue(CMD_ENQUEUE, 16'hFFFF, 4'h0);   // lowest priority: tail
      issue(CMD_ENQUEUE, 16'h0001, 4'h4);   // equal to the limit: tail
      issue(CMD_ENQUEUE, 16'h0002, 4'h5);   // inserted ahead of priority 0
      issue(CMD_ENQUEUE, 16'h0003, 4'hF);   // lands behind the equal head
      issue(CMD_ENQUEUE, 16'h0004, 4'h5);   // lands behind the equal priority 5
      issue(CMD_SEARCH,  16'hFFFF, 4'hF);   // hit
      issue(CMD_SEARCH,  16'h3039, 4'h0);   // miss
      issue(CMD_UNUSED,  16'hA5A5, 4'hA);   // unused command, queue not empty
      repeat (6) issue(CMD_DEQUEUE, 16'h5A5A, 4'h5);
      issue(CMD_DEQUEUE, 16'hFFFF, 4'hF);   // empty again
      drain();

      // Random part: phases alternate fill-heavy, drain-heavy and balanced mixes,
      // so the queue runs into both the full and the empty case.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0)      limit = '0;
         else if (phase == 1) limit = '1;
         else                 limit = PRIO_W'($urandom_range(0, 15));
         write_tail_limit(limit);
         case (phase % 3)
            0:       enq_share = 75;
            1:       enq_share = 20;
            default: enq_share = 50;
         endcase
         for (n = 0; n < PHASE_BEATS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
               cmd = CMD_UNUSED;
            else if (roll < 4 + enq_share)
               cmd = CMD_ENQUEUE;
            else if (roll < 4 + enq_share + (96 - enq_share) * 2 / 3)
               cmd = CMD_DEQUEUE;
            else
               cmd = CMD_SEARCH;
            issue(cmd, pick_id(), PRIO_W'($urandom_range(0, 15)));
         end
         drain();
      end

      // Hold off long enough for any stray beat to show up in the checker.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_threshold_priority_queue_unit OK");
      else
         $display("tb_threshold_priority_queue_unit NOT OK");
      $finish;
   end

endmodule
